>>> rtl/newton_quadratic_root_core_macros.svh
// Assertion macros for the newton quadratic root RTL.
`ifndef NEWTON_QUADRATIC_ROOT_CORE_MACROS_SVH
`define NEWTON_QUADRATIC_ROOT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NQR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nqr: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define NQR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nqr: next-cycle check failed");

`endif

>>> rtl/nqr_pkg.sv
// Package: widths, types, register codes and saturating fixed-point helpers.
package nqr_pkg;

   localparam int WORD_BITS     = 32;
   localparam int FRAC_BITS     = 16;
   localparam int PROD_BITS     = 2 * WORD_BITS;
   localparam int NUM_BITS      = WORD_BITS + FRAC_BITS;
   localparam int CNT_BITS      = $clog2(NUM_BITS + 1);
   localparam int TOL_BITS      = 16;
   localparam int LIMIT_BITS    = 20;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [WORD_BITS-1:0]        mag_type;
   typedef logic [PROD_BITS-1:0]        prod_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam prod_type MAG_LIMIT = {{WORD_BITS{1'b0}}, 1'b0, {(WORD_BITS-1){1'b1}}};

   localparam word_type                COEF_A_RESET = word_type'(65536);
   localparam word_type                COEF_B_RESET = '0;
   localparam word_type                COEF_C_RESET = '0;
   localparam logic [TOL_BITS-1:0]     TOL_RESET    = TOL_BITS'(1);
   localparam logic [LIMIT_BITS-1:0]   LIMIT_RESET  = LIMIT_BITS'(100000);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_COEF_A     = 3'd0,
      CSR_COEF_B     = 3'd1,
      CSR_COEF_C     = 3'd2,
      CSR_TOLERANCE  = 3'd3,
      CSR_ITER_LIMIT = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_XX,
      ST_MUL_BX,
      ST_MUL_AX,
      ST_MUL_AXX,
      ST_SUM_F,
      ST_ADD_C,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_CHECK,
      ST_DONE
   } nqr_state_type;

   typedef struct packed {
      logic                start;
      logic                neg;
      logic [NUM_BITS-1:0] num;
      mag_type             den;
   } div_req_type;

   typedef struct packed {
      logic     done;
      word_type quot;
   } div_rsp_type;

   function automatic mag_type mag_of(input word_type v);
      return v[WORD_BITS-1] ? mag_type'(-v) : mag_type'(v);
   endfunction

   // Signed value from sign and magnitude, saturated to the word.
   function automatic word_type from_mag(input logic neg, input prod_type m);
      word_type low;
      low = word_type'(m[WORD_BITS-1:0]);
      if (m > MAG_LIMIT) begin
         return neg ? WORD_MIN : WORD_MAX;
      end
      return neg ? -low : low;
   endfunction

   // Magnitude product scaled down by FRAC_BITS (or one less), truncated, saturated.
   function automatic word_type mul_sat(input prod_type p, input logic neg, input logic half);
      prod_type m;
      m = half ? (p >> (FRAC_BITS - 1)) : (p >> FRAC_BITS);
      return from_mag(neg, m);
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic signed [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end
      return word_type'(s[WORD_BITS-1:0]);
   endfunction

   function automatic word_type sat_sub(input word_type a, input word_type b);
      logic signed [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end
      return word_type'(s[WORD_BITS-1:0]);
   endfunction

endpackage

>>> rtl/nqr_div.sv
// Restoring divider, one quotient bit per cycle, signed saturated quotient.
module nqr_div
   import nqr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] acc_ff, acc_in;
   mag_type             rem_ff, rem_in;
   mag_type             den_ff;
   logic                neg_ff;

   logic [WORD_BITS:0]  trial;
   logic [WORD_BITS:0]  diff;
   logic                fits;

   // acc holds the remaining dividend bits on top, quotient bits shift in below
   assign trial = {rem_ff, acc_ff[NUM_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(NUM_BITS);
         acc_in  = div_req.num;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CNT_BITS'(1);
            acc_in = {acc_ff[NUM_BITS-2:0], fits};
            rem_in = fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      if (div_req.start) begin
         den_ff <= div_req.den;
         neg_ff <= div_req.neg;
      end
   end

   assign div_rsp.done = busy_ff && (cnt_ff == '0);
   assign div_rsp.quot = from_mag(neg_ff, prod_type'(acc_ff));

endmodule

>>> rtl/newton_quadratic_root_core.sv
// Newton root finder for a*x^2+b*x+c in signed Q16.16, one shared multiplier and divider.
// Per Newton iteration: x*x, b*x, 2*a*x, a*x*x, f sum, add c, bit-serial divide, check;
// a request adds an accept and a hand-over state; a zero derivative skips the divide.
// Throughput: one transaction at a time; req_ready is high only while the sequencer idles.
// Reset (synchronous, active high): clears sequencer and response valid, loads register
// defaults a=1.0, b=0, c=0, tolerance=1, iteration limit=100000.
`include "newton_quadratic_root_core_macros.svh"

module newton_quadratic_root_core
   import nqr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  word_type                 req_start_guess,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output word_type                 rsp_root,
   output logic                     rsp_status,
   output logic [LIMIT_BITS-1:0]    rsp_iterations_used,
   // configuration writes
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   word_type              coef_a_ff, coef_b_ff, coef_c_ff;
   logic [TOL_BITS-1:0]   tol_ff;
   logic [LIMIT_BITS-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= COEF_A_RESET;
         coef_b_ff <= COEF_B_RESET;
         coef_c_ff <= COEF_C_RESET;
         tol_ff    <= TOL_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COEF_A:     coef_a_ff <= word_type'(csr_wdata);
            CSR_COEF_B:     coef_b_ff <= word_type'(csr_wdata);
            CSR_COEF_C:     coef_c_ff <= word_type'(csr_wdata);
            CSR_TOLERANCE:  tol_ff    <= csr_wdata[TOL_BITS-1:0];
            CSR_ITER_LIMIT: limit_ff  <= csr_wdata[LIMIT_BITS-1:0];
            default: ;      // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Iteration state
   // ---------------------------------------------------------------
   nqr_state_type         state_ff, state_in;

   word_type              x_ff;     // current estimate
   word_type              xx_ff;    // x*x
   word_type              bx_ff;    // b*x
   word_type              d_ff;     // f'(x) = 2*a*x + b
   word_type              f_ff;     // f(x)
   word_type              xn_ff;    // next estimate
   logic [LIMIT_BITS-1:0] n_ff;     // completed updates
   word_type              res_root_ff;
   logic                  res_status_ff;

   logic                  rsp_valid_ff;
   word_type              rsp_root_ff;
   logic                  rsp_status_ff;
   logic [LIMIT_BITS-1:0] rsp_iter_ff;

   // Shared multiplier: magnitudes multiply, sign and scale ride along.
   word_type              mul_op_a, mul_op_b;
   logic                  mul_half;
   prod_type              mul_prod_ff;
   logic                  mul_neg_ff;
   logic                  mul_half_ff;
   word_type              mul_res;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   // status terms
   logic                  limit_zero;
   logic                  d_zero;
   logic [LIMIT_BITS-1:0] n_next;
   logic                  at_limit;
   word_type              change;
   logic                  converged;

   // sequencer strobes
   logic ld_start, ld_xx, ld_bx, ld_d, ld_f_mul, ld_f_c, ld_xn;
   logic advance, fin_ok, fin_fail, ld_rsp;

   always_ff @(posedge clock) begin
      mul_prod_ff <= prod_type'(mag_of(mul_op_a)) * prod_type'(mag_of(mul_op_b));
      mul_neg_ff  <= mul_op_a[WORD_BITS-1] ^ mul_op_b[WORD_BITS-1];
      mul_half_ff <= mul_half;
   end

   // product of the previous cycle, truncated and saturated
   assign mul_res = mul_sat(mul_prod_ff, mul_neg_ff, mul_half_ff);

   nqr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign limit_zero = (limit_ff == '0);
   assign d_zero     = (d_ff == '0);
   assign n_next     = n_ff + LIMIT_BITS'(1);
   assign at_limit   = (n_next == limit_ff);
   assign change     = sat_sub(xn_ff, x_ff);
   assign converged  = (mag_of(change) <= mag_type'(tol_ff));

   // ---------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = limit_zero ? ST_DONE : ST_MUL_XX;
            end
         end
         ST_MUL_XX:  state_in = ST_MUL_BX;
         ST_MUL_BX:  state_in = ST_MUL_AX;
         ST_MUL_AX:  state_in = ST_MUL_AXX;
         ST_MUL_AXX: state_in = ST_SUM_F;
         ST_SUM_F:   state_in = ST_ADD_C;
         ST_ADD_C:   state_in = d_zero ? ST_DONE : ST_DIV_GO;
         ST_DIV_GO:  state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (converged || at_limit) ? ST_DONE : ST_MUL_XX;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer: outputs (operand select, load strobes, divider start)
   // ---------------------------------------------------------------
   always_comb begin
      req_ready   = 1'b0;
      mul_op_a    = x_ff;
      mul_op_b    = x_ff;
      mul_half    = 1'b0;
      ld_start    = 1'b0;
      ld_xx       = 1'b0;
      ld_bx       = 1'b0;
      ld_d        = 1'b0;
      ld_f_mul    = 1'b0;
      ld_f_c      = 1'b0;
      ld_xn       = 1'b0;
      advance     = 1'b0;
      fin_ok      = 1'b0;
      fin_fail    = 1'b0;
      ld_rsp      = 1'b0;
      div_req.start = 1'b0;
      div_req.neg   = f_ff[WORD_BITS-1] ^ d_ff[WORD_BITS-1];
      div_req.num   = {mag_of(f_ff), {FRAC_BITS{1'b0}}};
      div_req.den   = mag_of(d_ff);
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ld_start = 1'b1;
               fin_fail = limit_zero;
            end
         end
         ST_MUL_XX: ;                       // x*x issued by default
         ST_MUL_BX: begin
            mul_op_a = coef_b_ff;
            ld_xx    = 1'b1;
         end
         ST_MUL_AX: begin
            mul_op_a = coef_a_ff;
            mul_half = 1'b1;                // 2*a*x: one fraction bit less
            ld_bx    = 1'b1;
         end
         ST_MUL_AXX: begin
            mul_op_a = coef_a_ff;
            mul_op_b = xx_ff;
            ld_d     = 1'b1;
         end
         ST_SUM_F:   ld_f_mul = 1'b1;
         ST_ADD_C: begin
            ld_f_c   = 1'b1;
            fin_fail = d_zero;
         end
         ST_DIV_GO:  div_req.start = 1'b1;
         ST_DIV_WAIT: ld_xn = div_rsp.done;
         ST_CHECK: begin
            fin_ok   = converged;
            advance  = !converged;
            fin_fail = !converged && at_limit;
         end
         ST_DONE:    ld_rsp = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------
   // Datapath registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (ld_start) begin
         x_ff <= req_start_guess;
         n_ff <= '0;
      end
      if (ld_xx) begin
         xx_ff <= mul_res;
      end
      if (ld_bx) begin
         bx_ff <= mul_res;
      end
      if (ld_d) begin
         d_ff <= sat_add(mul_res, coef_b_ff);
      end
      if (ld_f_mul) begin
         f_ff <= sat_add(mul_res, bx_ff);
      end
      if (ld_f_c) begin
         f_ff <= sat_add(f_ff, coef_c_ff);
      end
      if (ld_xn) begin
         xn_ff <= sat_sub(x_ff, div_rsp.quot);
      end
      if (state_ff == ST_CHECK) begin
         n_ff <= n_next;
      end
      if (advance) begin
         x_ff <= xn_ff;
      end
      if (fin_ok) begin
         res_root_ff   <= xn_ff;
         res_status_ff <= 1'b0;
      end
      if (fin_fail) begin
         res_root_ff   <= '0;
         res_status_ff <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Response register: holds a finished transaction until taken
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ld_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_rsp) begin
         rsp_root_ff   <= res_root_ff;
         rsp_status_ff <= res_status_ff;
         rsp_iter_ff   <= n_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_root            = rsp_root_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_iterations_used = rsp_iter_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `NQR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `NQR_ASSERT_NOW(a_fail_root_zero, clock, reset, rsp_valid && rsp_status, rsp_root == '0)
   `NQR_ASSERT_NOW(a_iter_in_limit, clock, reset, rsp_valid, rsp_iterations_used <= limit_ff)
   `NQR_ASSERT_NOW(a_div_nonzero, clock, reset, div_req.start, div_req.den != '0)

endmodule

>>> test/newton_quadratic_root_core_tb.sv
// Testbench for newton_quadratic_root_core: directed and random roots checked against a predictor.
`timescale 1ns / 1ps

module newton_quadratic_root_core_tb;
   import nqr_pkg::*;

   typedef longint unsigned ulong_type;

   // Coefficients sign-extended, tolerance and limit zero-extended to 64 bits, for the predictor.
   typedef struct packed {
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] c;
      logic [63:0]        tol;
      logic [63:0]        limit;
   } quad_cfg_type;

   typedef struct packed {
      word_type              root;
      logic                  status;
      logic [LIMIT_BITS-1:0] iters;
   } root_report_type;

   localparam logic      STATUS_CONVERGED = 1'b0;
   localparam logic      STATUS_NO_ROOT   = 1'b1;
   localparam int        Q_ONE            = 1 << FRAC_BITS;
   localparam longint    WORD_HI          = longint'(WORD_MAX);
   localparam longint    WORD_LO          = longint'(WORD_MIN);
   localparam ulong_type NO_ITER_CAP      = 64'hFFFF_FFFF_FFFF_FFFF;
   // Guesses sent under a huge iteration limit must settle within this many steps.
   localparam int        MAX_RUN_ITERS    = 200;
   localparam int        LONG_HOLD        = 3000;
   localparam int        SETTLE_CYCLES    = 120;
   localparam int        WATCHDOG_LIMIT   = 50000;
   localparam int        RANDOM_PHASES    = 28;
   localparam int        ITEMS_PER_PHASE  = 30;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   word_type                 req_start_guess = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   word_type                 rsp_root;
   logic                     rsp_status;
   logic [LIMIT_BITS-1:0]    rsp_iterations_used;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   newton_quadratic_root_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_guess    (req_start_guess),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_root           (rsp_root),
      .rsp_status         (rsp_status),
      .rsp_iterations_used(rsp_iterations_used),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Fixed-point predictor. All values live in 64-bit signed containers and are
   // saturated back to the 32-bit word after every operation.
   // ---------------------------------------------------------------------------
   function automatic longint clamp_word(input longint v);
      if (v > WORD_HI) return WORD_HI;
      if (v < WORD_LO) return WORD_LO;
      return v;
   endfunction

   function automatic ulong_type abs_of(input longint v);
      return v < 0 ? ulong_type'(-v) : ulong_type'(v);
   endfunction

   function automatic longint signed_from_mag(input logic neg, input ulong_type m);
      if (m > ulong_type'(WORD_HI)) return neg ? WORD_LO : WORD_HI;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   // (p*q) >> sh on magnitudes, i.e. truncation toward zero
   function automatic longint fixed_mul(input longint p, input longint q, input int sh);
      ulong_type m;
      m = (abs_of(p) * abs_of(q)) >> sh;
      return signed_from_mag((p < 0) != (q < 0), m);
   endfunction

   function automatic longint fixed_div(input longint n, input longint d);
      ulong_type m;
      m = (abs_of(n) << FRAC_BITS) / abs_of(d);
      return signed_from_mag((n < 0) != (d < 0), m);
   endfunction

   // Runs the Newton loop from one start guess; iter_cap only shortens bound checks.
   function automatic root_report_type newton_solve(input quad_cfg_type cfg,
                                                    input word_type guess,
                                                    input ulong_type iter_cap);
      longint          ca, cb, cc, x, xx, f, d, xn;
      ulong_type       n;
      root_report_type r;
      ca       = cfg.a;
      cb       = cfg.b;
      cc       = cfg.c;
      x        = longint'(guess);
      n        = 0;
      r.root   = '0;
      r.status = STATUS_NO_ROOT;
      while (n < cfg.limit && n < iter_cap) begin
         xx = fixed_mul(x, x, FRAC_BITS);
         f  = clamp_word(clamp_word(fixed_mul(ca, xx, FRAC_BITS) + fixed_mul(cb, x, FRAC_BITS))
                         + cc);
         // 2*a*x is one product scaled by one bit less
         d  = clamp_word(fixed_mul(ca, x, FRAC_BITS - 1) + cb);
         if (d == 0) break;   // flat derivative: give up, this step is not counted
         xn = clamp_word(x - fixed_div(f, d));
         n++;
         if (abs_of(clamp_word(xn - x)) <= cfg.tol) begin
            r.root   = word_type'(xn);
            r.status = STATUS_CONVERGED;
            break;
         end
         x = xn;
      end
      r.iters = n[LIMIT_BITS-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Scoreboard: register shadow, expected results, result comparison.
   // outstanding is updated with NBAs so the stimulus reads a stable count.
   // ---------------------------------------------------------------------------
   quad_cfg_type    active_cfg;
   quad_cfg_type    planned_cfg;   // what the stimulus believes it has programmed
   root_report_type expected_roots[$];
   root_report_type want;
   int              outstanding = 0;
   int              fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         active_cfg.a     <= longint'(COEF_A_RESET);
         active_cfg.b     <= longint'(COEF_B_RESET);
         active_cfg.c     <= longint'(COEF_C_RESET);
         active_cfg.tol   <= 64'(TOL_RESET);
         active_cfg.limit <= 64'(LIMIT_RESET);
         outstanding      <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COEF_A:     active_cfg.a     <= $signed(csr_wdata);
               CSR_COEF_B:     active_cfg.b     <= $signed(csr_wdata);
               CSR_COEF_C:     active_cfg.c     <= $signed(csr_wdata);
               CSR_TOLERANCE:  active_cfg.tol   <= 64'(csr_wdata[TOL_BITS-1:0]);
               CSR_ITER_LIMIT: active_cfg.limit <= 64'(csr_wdata[LIMIT_BITS-1:0]);
               default: ;   // unmapped index: dropped by the block
            endcase
         end
         if (req_valid && req_ready) begin
            expected_roots.push_back(newton_solve(active_cfg, req_start_guess, NO_ITER_CAP));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_roots.size() == 0) begin
               $error("result with no transaction pending: root %0d", rsp_root);
               fail_count++;
            end else begin
               want = expected_roots.pop_front();
               if (rsp_root !== want.root) begin
                  $error("root: expected %0d, actual %0d", want.root, rsp_root);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_iterations_used !== want.iters) begin
                  $error("iterations_used: expected %0d, actual %0d",
                         want.iters, rsp_iterations_used);
                  fail_count++;
               end
            end
         end
         outstanding <= outstanding + int'(req_valid && req_ready) - int'(rsp_valid && rsp_ready);
      end
   end

   // ---------------------------------------------------------------------------
   // Result sink. After each transaction it draws a stall, counted only while a
   // result is offered. A long hold-off is requested by bumping holds_asked.
   // ---------------------------------------------------------------------------
   logic        no_idle = 1'b0;
   int          holds_asked = 0;
   int          holds_served;
   int          hold_left;
   int          ready_delay;
   int unsigned sink_draw;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         ready_delay  <= 0;
         hold_left    <= 0;
         holds_served <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_asked;
         hold_left    <= LONG_HOLD;
         rsp_ready    <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         sink_draw   = no_idle ? 0 : $urandom_range(0, 15);
         ready_delay <= sink_draw;
         rsp_ready   <= (sink_draw == 0);
      end else if (ready_delay != 0) begin
         if (rsp_valid) ready_delay <= ready_delay - 1;
         rsp_ready <= rsp_valid && (ready_delay == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: any stretch without a transaction or register write this long is a hang.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers. Every task starts and ends right after a rising edge.
   // ---------------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [31:0] qa, input logic [31:0] qb,
                               input logic [31:0] qc, input logic [31:0] tol_data,
                               input logic [31:0] limit_data);
      write_reg(CSR_COEF_A, qa);
      write_reg(CSR_COEF_B, qb);
      write_reg(CSR_COEF_C, qc);
      write_reg(CSR_TOLERANCE, tol_data);
      write_reg(CSR_ITER_LIMIT, limit_data);
      csr_wr_en         <= 1'b0;
      planned_cfg.a     = $signed(qa);
      planned_cfg.b     = $signed(qb);
      planned_cfg.c     = $signed(qc);
      planned_cfg.tol   = 64'(tol_data[TOL_BITS-1:0]);
      planned_cfg.limit = 64'(limit_data[LIMIT_BITS-1:0]);
   endtask

   // One request transaction; valid stays up afterwards unless the next gap drops it.
   task automatic send_guess(input word_type guess);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_start_guess <= guess;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic word_type pick_extreme();
      case ($urandom_range(0, 5))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         2:       return '0;
         3:       return word_type'(Q_ONE);
         4:       return word_type'(-Q_ONE);
         default: return word_type'($urandom());
      endcase
   endfunction

   // Mostly a*(x-r1)*(x-r2) with real roots inside +/-16, plus complex pairs,
   // linear and flat forms, and raw or extreme coefficient sets.
   task automatic draw_quadratic(output logic [31:0] qa, output logic [31:0] qb,
                                 output logic [31:0] qc);
      int unsigned kind;
      longint      ca, cb, cc, r1, r2;
      kind = $urandom_range(0, 9);
      ca   = longint'($urandom_range(Q_ONE / 4, 4 * Q_ONE));
      if ($urandom_range(0, 1) == 1) ca = -ca;
      r1 = longint'($urandom_range(0, 32 * Q_ONE)) - 16 * Q_ONE;
      r2 = longint'($urandom_range(0, 32 * Q_ONE)) - 16 * Q_ONE;
      cb = clamp_word(-((ca * (r1 + r2)) >>> FRAC_BITS));
      cc = clamp_word((((ca * r1) >>> FRAC_BITS) * r2) >>> FRAC_BITS);
      case (kind)
         6: begin   // roots r1 +/- i*r2: no real root when r2 is nonzero
            cb = clamp_word(-((ca * 2 * r1) >>> FRAC_BITS));
            cc = clamp_word((ca * ((r1 * r1 + r2 * r2) >>> FRAC_BITS)) >>> FRAC_BITS);
         end
         7: begin
            ca = longint'(word_type'($urandom()));
            cb = longint'(word_type'($urandom()));
            cc = longint'(word_type'($urandom()));
         end
         8: begin
            ca = longint'(pick_extreme());
            cb = longint'(pick_extreme());
            cc = longint'(pick_extreme());
         end
         9: begin   // linear; b may come out zero
            ca = 0;
            cb = longint'($urandom_range(0, 8 * Q_ONE)) - 4 * Q_ONE;
            cc = longint'($urandom_range(0, 64 * Q_ONE)) - 32 * Q_ONE;
         end
         default: ;
      endcase
      qa = ca[31:0];
      qb = cb[31:0];
      qc = cc[31:0];
   endtask

   // Unused upper bits are filled at random; the block must mask them off.
   function automatic logic [31:0] draw_tolerance();
      int unsigned tol;
      tol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 64);
      return ($urandom() & 32'hFFFF_0000) | tol;
   endfunction

   function automatic logic [31:0] draw_limit();
      int unsigned lim;
      lim = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 32);
      return ($urandom() & 32'hFFF0_0000) | lim;
   endfunction

   function automatic word_type draw_guess();
      if ($urandom_range(0, 3) == 0) return word_type'($urandom());
      return word_type'(int'($urandom_range(0, 64 * Q_ONE)) - 32 * Q_ONE);
   endfunction

   // Under a huge limit a bad guess can crawl for tens of thousands of steps.
   function automatic logic settles_quickly(input word_type guess);
      root_report_type r;
      r = newton_solve(planned_cfg, guess, ulong_type'(MAX_RUN_ITERS + 1));
      return r.iters <= MAX_RUN_ITERS;
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Registers straight out of reset: f = x^2, tolerance 1 LSB.
   task automatic test_reset_defaults();
      send_guess('0);                          // derivative zero at once
      send_guess(word_type'(1));               // step rounds to nothing
      send_guess(word_type'(3 * Q_ONE));
      send_guess(word_type'(-100 * Q_ONE));
      drain_results();
   endtask

   // x^2 - 4 with a short limit so saturated starts run out of steps.
   task automatic test_field_extremes();
      apply_config(Q_ONE, '0, -4 * Q_ONE, 16, 20);
      send_guess(WORD_MAX);
      send_guess(WORD_MIN);
      send_guess(word_type'(-1));
      send_guess(word_type'(3 * Q_ONE));
      send_guess(word_type'(-3 * Q_ONE));
      send_guess(word_type'(2 * Q_ONE));       // exact root: zero step
      drain_results();
   endtask

   task automatic test_limit_edges();
      // upper bits set, low 20 clear: limit of zero, no step is taken
      apply_config(Q_ONE, '0, -4 * Q_ONE, 16, 32'hFFF0_0000);
      send_guess(word_type'(3 * Q_ONE));
      drain_results();
      apply_config(Q_ONE, '0, -4 * Q_ONE, 16, 1);
      send_guess(word_type'(3 * Q_ONE));
      drain_results();
      apply_config(Q_ONE, '0, -4 * Q_ONE, 32'h0000_FFFF, 32'h000F_FFFF);
      send_guess(word_type'(3 * Q_ONE));
      drain_results();
   endtask

   task automatic test_zero_derivative();
      // x^2 - 2x: derivative 2x - 2 vanishes at the start guess 1.0
      apply_config(Q_ONE, -2 * Q_ONE, '0, 1, 20);
      send_guess(word_type'(Q_ONE));
      drain_results();
      // constant function: derivative is always zero
      apply_config('0, '0, 5 * Q_ONE, 1, 20);
      send_guess(draw_guess());
      drain_results();
      // linear x - 3: one exact step, then a zero step
      apply_config('0, Q_ONE, -3 * Q_ONE, 0, 20);
      send_guess(word_type'(7 * Q_ONE));
      drain_results();
   endtask

   task automatic test_coef_extremes();
      apply_config(WORD_MIN, WORD_MAX, WORD_MIN, 32'h0000_FFFF, 8);
      send_guess(word_type'(Q_ONE));
      send_guess(WORD_MAX);
      drain_results();
      apply_config(WORD_MAX, WORD_MIN, WORD_MAX, 0, 8);
      send_guess(word_type'(-Q_ONE));
      send_guess(WORD_MIN);
      drain_results();
   endtask

   // Writes past the last register must leave the programmed set untouched.
   task automatic test_unused_registers();
      int i;
      for (i = int'(CSR_ITER_LIMIT) + 1; i < (1 << CSR_IDX_BITS); i++) begin
         write_reg(CSR_IDX_BITS'(i), $urandom());
      end
      csr_wr_en <= 1'b0;
      send_guess(word_type'(3 * Q_ONE));
      drain_results();
   endtask

   task automatic test_random_quadratics();
      int          phase, k, tries;
      logic        huge_limit;
      logic [31:0] qa, qb, qc, lim;
      word_type    guess;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         draw_quadratic(qa, qb, qc);
         huge_limit = (phase % 7 == 3);
         lim = draw_limit();
         if (huge_limit) lim = (phase % 2 == 1) ? 32'h000F_FFFF : 32'(LIMIT_RESET);
         apply_config(qa, qb, qc, draw_tolerance(), lim);
         no_idle <= ($urandom_range(0, 3) == 0);
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            guess = draw_guess();
            tries = 0;
            while (huge_limit && !settles_quickly(guess) && tries < 20) begin
               guess = draw_guess();
               tries++;
            end
            if (!huge_limit || settles_quickly(guess)) send_guess(guess);
         end
         drain_results();
      end
      no_idle <= 1'b0;
   endtask

   // Sink holds off for a long stretch while the source keeps offering, so the
   // one-deep core fills and holds req_ready low.
   task automatic test_output_backpressure();
      int k;
      apply_config(Q_ONE, '0, -2 * Q_ONE, 8, 12);
      no_idle     <= 1'b1;
      holds_asked <= holds_asked + 1;
      for (k = 0; k < 12; k++) send_guess(draw_guess());
      drain_results();
      no_idle <= 1'b0;
   endtask

   // Source stops now and then until the core has handed back everything.
   task automatic test_sender_pause();
      int          k;
      logic [31:0] qa, qb, qc;
      draw_quadratic(qa, qb, qc);
      apply_config(qa, qb, qc, draw_tolerance(), 24);
      for (k = 0; k < 60; k++) begin
         send_guess(draw_guess());
         if ($urandom_range(0, 5) == 0) drain_results();
      end
      drain_results();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_field_extremes();
      test_limit_edges();
      test_zero_derivative();
      test_coef_extremes();
      test_unused_registers();
      test_random_quadratics();
      test_output_backpressure();
      test_sender_pause();
      // let any stray result surface before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_roots.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/nqr_pkg.sv
rtl/nqr_div.sv
rtl/newton_quadratic_root_core.sv
test/newton_quadratic_root_core_tb.sv
